@@ src/ssp_pkg.sv @@
// shared types and codes of the scanf conversion specification parser
package ssp_pkg;

   // payload field types
   typedef logic [7:0]  fmt_byte_type;
   typedef logic [15:0] pos_type;
   typedef logic [3:0]  size_type;
   typedef logic [3:0]  kind_type;
   typedef logic [63:0] half_set_type;

   // number of characters covered by a scanset
   localparam int SET_CHARS = 128;
   localparam int CHAR_W    = $clog2(SET_CHARS);
   typedef logic [SET_CHARS-1:0] set_type;

   // size modifier codes
   localparam size_type SIZE_NONE = 4'd0;
   localparam size_type SIZE_HH   = 4'd1;
   localparam size_type SIZE_H    = 4'd2;
   localparam size_type SIZE_L    = 4'd3;
   localparam size_type SIZE_LL   = 4'd4;
   localparam size_type SIZE_J    = 4'd5;
   localparam size_type SIZE_Z    = 4'd6;
   localparam size_type SIZE_T    = 4'd7;
   localparam size_type SIZE_BIG_L = 4'd8;

   // conversion kind codes
   localparam kind_type KIND_INT     = 4'd0;
   localparam kind_type KIND_UNSIGN  = 4'd1;
   localparam kind_type KIND_BIN     = 4'd2;
   localparam kind_type KIND_OCT     = 4'd3;
   localparam kind_type KIND_HEX     = 4'd4;
   localparam kind_type KIND_FLT_F   = 4'd5;
   localparam kind_type KIND_FLT_A   = 4'd6;
   localparam kind_type KIND_FLT_E   = 4'd7;
   localparam kind_type KIND_FLT_G   = 4'd8;
   localparam kind_type KIND_CHAR    = 4'd9;
   localparam kind_type KIND_STRING  = 4'd10;
   localparam kind_type KIND_SET     = 4'd11;
   localparam kind_type KIND_POINTER = 4'd12;
   localparam kind_type KIND_COUNT   = 4'd13;
   localparam kind_type KIND_UNKNOWN = 4'd14;

endpackage

@@ src/ssp_if.sv @@
// valid/ready channel interfaces for format bytes and specification descriptors
interface ssp_req_if;
   logic                  valid;
   logic                  ready;
   ssp_pkg::fmt_byte_type fmt_byte;

   modport source (output valid, output fmt_byte, input ready);
   modport sink   (input valid, input fmt_byte, output ready);
endinterface

interface ssp_rsp_if;
   logic                  valid;
   logic                  ready;
   ssp_pkg::pos_type      arg_position;
   logic                  suppress_assign;
   logic                  group_digits;
   logic                  allocate_buffer;
   logic                  upper_case;
   ssp_pkg::pos_type      field_width;
   ssp_pkg::size_type     size_modifier;
   ssp_pkg::kind_type     conv_kind;
   ssp_pkg::half_set_type set_low_bits;
   ssp_pkg::half_set_type set_high_bits;

   modport source (output valid, output arg_position, output suppress_assign,
                   output group_digits, output allocate_buffer, output upper_case,
                   output field_width, output size_modifier, output conv_kind,
                   output set_low_bits, output set_high_bits, input ready);
   modport sink   (input valid, input arg_position, input suppress_assign,
                   input group_digits, input allocate_buffer, input upper_case,
                   input field_width, input size_modifier, input conv_kind,
                   input set_low_bits, input set_high_bits, output ready);
endinterface

@@ src/ssp_digit_acc.sv @@
// saturating decimal accumulator: acc * 10 + digit, clamped to all ones
module ssp_digit_acc #(
   parameter int NUM_BITS = 16
) (
   input  logic [NUM_BITS-1:0] acc,
   input  logic [3:0]          digit,
   output logic [NUM_BITS-1:0] result
);

   logic [NUM_BITS+3:0] sum;

   // acc * 8 + acc * 2 + digit
   assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_BITS{1'b0}}, digit};

   // any bit above the accumulator width means overflow
   assign result = (|sum[NUM_BITS+3:NUM_BITS]) ? {NUM_BITS{1'b1}} : sum[NUM_BITS-1:0];

endmodule

@@ src/scanf_spec_parser.sv @@
// top level of the scanf conversion specification parser
//
// req_chan carries the bytes that follow a percent sign, one byte per item;
// a zero byte ends the format. rsp_chan carries one descriptor per finished
// specification: argument position, flags, width, size modifier, conversion
// kind and, for a bracket conversion, the 128-bit scanset.
// Both channels move an item at a clock edge where valid and ready are high.
// Throughput: one byte per cycle while the input register is not stalled. A
// byte sits in the input register while the parse step (one saturating
// multiply-add by ten and the scanset range compare) runs; the descriptor
// is then written to the result register, which drives rsp_chan.valid,
// and leaves from there once the receiver is ready.
// When the receiver stalls, the result register holds its descriptor; the
// input register still advances on bytes that produce no descriptor and
// stops only when a new descriptor would overwrite the held one, and then
// req_chan.ready drops.
// Synchronous reset clears the parse state and both valid flags; the block
// is ready for a byte as soon as reset is released.
module scanf_spec_parser #(
   parameter int NUM_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   ssp_req_if.sink           req_chan,
   ssp_rsp_if.source         rsp_chan
);

   typedef enum logic [3:0] {
      PH_START, PH_ARGNUM, PH_FLAGS, PH_WIDTH, PH_LEN,
      PH_H, PH_L, PH_CONV, PH_SET, PH_CARET
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE, PEND_CHAR, PEND_DASH
   } pend_type;

   localparam int CW = ssp_pkg::CHAR_W;

   // format characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_B   = 8'h42;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_UP_G   = 8'h47;
   localparam logic [7:0] CH_UP_L   = 8'h4C;
   localparam logic [7:0] CH_UP_O   = 8'h4F;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_C   = 8'h63;
   localparam logic [7:0] CH_LO_D   = 8'h64;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_G   = 8'h67;
   localparam logic [7:0] CH_LO_H   = 8'h68;
   localparam logic [7:0] CH_LO_I   = 8'h69;
   localparam logic [7:0] CH_LO_J   = 8'h6A;
   localparam logic [7:0] CH_LO_L   = 8'h6C;
   localparam logic [7:0] CH_LO_M   = 8'h6D;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_O   = 8'h6F;
   localparam logic [7:0] CH_LO_P   = 8'h70;
   localparam logic [7:0] CH_LO_S   = 8'h73;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_U   = 8'h75;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   // conversion letter decode: kind in the low bits, upper case flag on top
   function automatic logic [4:0] classify(input logic [7:0] b);
      logic [4:0] r;
      unique case (b)
         CH_LO_D, CH_LO_I: r = {1'b0, ssp_pkg::KIND_INT};
         CH_LO_U:          r = {1'b0, ssp_pkg::KIND_UNSIGN};
         CH_UP_B:          r = {1'b1, ssp_pkg::KIND_BIN};
         CH_LO_B:          r = {1'b0, ssp_pkg::KIND_BIN};
         CH_UP_O:          r = {1'b1, ssp_pkg::KIND_OCT};
         CH_LO_O:          r = {1'b0, ssp_pkg::KIND_OCT};
         CH_UP_X:          r = {1'b1, ssp_pkg::KIND_HEX};
         CH_LO_X:          r = {1'b0, ssp_pkg::KIND_HEX};
         CH_UP_F:          r = {1'b1, ssp_pkg::KIND_FLT_F};
         CH_LO_F:          r = {1'b0, ssp_pkg::KIND_FLT_F};
         CH_UP_A:          r = {1'b1, ssp_pkg::KIND_FLT_A};
         CH_LO_A:          r = {1'b0, ssp_pkg::KIND_FLT_A};
         CH_UP_E:          r = {1'b1, ssp_pkg::KIND_FLT_E};
         CH_LO_E:          r = {1'b0, ssp_pkg::KIND_FLT_E};
         CH_UP_G:          r = {1'b1, ssp_pkg::KIND_FLT_G};
         CH_LO_G:          r = {1'b0, ssp_pkg::KIND_FLT_G};
         CH_LO_C:          r = {1'b0, ssp_pkg::KIND_CHAR};
         CH_LO_S:          r = {1'b0, ssp_pkg::KIND_STRING};
         CH_LBRACK:        r = {1'b0, ssp_pkg::KIND_SET};
         CH_LO_P:          r = {1'b0, ssp_pkg::KIND_POINTER};
         CH_LO_N:          r = {1'b0, ssp_pkg::KIND_COUNT};
         default:          r = {1'b0, ssp_pkg::KIND_UNKNOWN};
      endcase
      return r;
   endfunction

   // input register
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;

   // parse state
   phase_type             phase_ff, phase_in;
   logic [NUM_BITS-1:0]   accum_ff, accum_in;
   logic [NUM_BITS-1:0]   arg_pos_ff, arg_pos_in;
   logic                  suppress_ff, suppress_in;
   logic                  group_ff, group_in;
   logic                  alloc_ff, alloc_in;
   ssp_pkg::size_type     size_ff, size_in;
   ssp_pkg::set_type      set_ff, set_in;
   logic                  negated_ff, negated_in;
   logic                  first_done_ff, first_done_in;
   logic [CW-1:0]         pend_char_ff, pend_char_in;
   pend_type              pend_ff, pend_in;

   // result register
   logic                  rsp_valid_ff;
   ssp_pkg::pos_type      rsp_arg_ff;
   logic                  rsp_suppress_ff;
   logic                  rsp_group_ff;
   logic                  rsp_alloc_ff;
   logic                  rsp_upper_ff;
   ssp_pkg::pos_type      rsp_width_ff;
   ssp_pkg::size_type     rsp_size_ff;
   ssp_pkg::kind_type     rsp_kind_ff;
   ssp_pkg::set_type      rsp_set_ff;

   // step outputs
   logic                  fire;
   logic                  emit;
   ssp_pkg::kind_type     emit_kind;
   logic                  emit_upper;
   ssp_pkg::set_type      set_work;
   logic [NUM_BITS-1:0]   acc_next;
   ssp_pkg::set_type      range_mask;
   logic [CW-1:0]         range_hi;

   // saturating width and position accumulator
   ssp_digit_acc #(
      .NUM_BITS (NUM_BITS)
   ) u_digit_acc (
      .acc    (accum_ff),
      .digit  (in_byte_ff[3:0]),
      .result (acc_next)
   );

   // handshake: step runs unless it would overwrite a held descriptor
   assign fire          = in_valid_ff && (!emit || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;

   // range mask from the pending start to the clamped end
   always_comb begin
      range_hi = in_byte_ff[7] ? {CW{1'b1}} : in_byte_ff[CW-1:0];
      for (int i = 0; i < ssp_pkg::SET_CHARS; i++) begin
         range_mask[i] = (CW'(i) >= pend_char_ff) && (CW'(i) <= range_hi);
      end
   end

   // one parse step over the byte in the input register
   always_comb begin
      logic [7:0]        b;
      logic              dig;
      logic              done;
      logic              set_all;
      logic [4:0]        cls;
      phase_type         ph;
      ssp_pkg::set_type  mask;
      phase_type         phase_w;
      logic [NUM_BITS-1:0] accum_w;
      logic [NUM_BITS-1:0] arg_pos_w;
      logic              suppress_w;
      logic              group_w;
      logic              alloc_w;
      ssp_pkg::size_type size_w;
      logic              negated_w;
      logic              first_done_w;
      logic [CW-1:0]     pend_char_w;
      pend_type          pend_w;

      b            = in_byte_ff;
      dig          = (b >= CH_ZERO) && (b <= CH_NINE);
      done         = 1'b0;
      set_all      = 1'b0;
      mask         = '0;
      cls          = '0;
      ph           = phase_ff;
      emit         = 1'b0;
      emit_kind    = ssp_pkg::KIND_UNKNOWN;
      emit_upper   = 1'b0;
      phase_w      = phase_ff;
      accum_w      = accum_ff;
      arg_pos_w    = arg_pos_ff;
      suppress_w   = suppress_ff;
      group_w      = group_ff;
      alloc_w      = alloc_ff;
      size_w       = size_ff;
      negated_w    = negated_ff;
      first_done_w = first_done_ff;
      pend_char_w  = pend_char_ff;
      pend_w       = pend_ff;

      // first byte: a digit may open an argument position
      if (ph == PH_START) begin
         if (dig) begin
            accum_w = acc_next;
            phase_w = PH_ARGNUM;
            done    = 1'b1;
         end else begin
            ph = PH_FLAGS;
         end
      end

      // argument position digits, closed by a dollar sign
      if (!done && ph == PH_ARGNUM) begin
         if (dig) begin
            accum_w = acc_next;
            done    = 1'b1;
         end else if (b == CH_DOLLAR && accum_ff != '0) begin
            arg_pos_w = accum_ff;
            accum_w   = '0;
            phase_w   = PH_FLAGS;
            done      = 1'b1;
         end else begin
            ph = PH_LEN;
         end
      end

      // flags, then the first width digit
      if (!done && ph == PH_FLAGS) begin
         if (b == CH_STAR) begin
            suppress_w = 1'b1;
            done       = 1'b1;
         end else if (b == CH_APOS) begin
            group_w = 1'b1;
            done    = 1'b1;
         end else if (b == CH_LO_M) begin
            alloc_w = 1'b1;
            done    = 1'b1;
         end else if (dig) begin
            accum_w = acc_next;
            phase_w = PH_WIDTH;
            done    = 1'b1;
         end else begin
            ph = PH_LEN;
         end
      end

      // remaining width digits
      if (!done && ph == PH_WIDTH) begin
         if (dig) begin
            accum_w = acc_next;
            done    = 1'b1;
         end else begin
            ph = PH_LEN;
         end
      end

      // size modifier
      if (!done && ph == PH_LEN) begin
         done = 1'b1;
         case (b)
            CH_LO_H: phase_w = PH_H;
            CH_LO_L: phase_w = PH_L;
            CH_UP_L: begin
               size_w  = ssp_pkg::SIZE_BIG_L;
               phase_w = PH_CONV;
            end
            CH_LO_J: begin
               size_w  = ssp_pkg::SIZE_J;
               phase_w = PH_CONV;
            end
            CH_LO_Z: begin
               size_w  = ssp_pkg::SIZE_Z;
               phase_w = PH_CONV;
            end
            CH_LO_T: begin
               size_w  = ssp_pkg::SIZE_T;
               phase_w = PH_CONV;
            end
            default: begin
               done = 1'b0;
               ph   = PH_CONV;
            end
         endcase
      end

      // second letter of hh or ll
      if (!done && ph == PH_H) begin
         phase_w = PH_CONV;
         if (b == CH_LO_H) begin
            size_w = ssp_pkg::SIZE_HH;
            done   = 1'b1;
         end else begin
            size_w = ssp_pkg::SIZE_H;
            ph     = PH_CONV;
         end
      end
      if (!done && ph == PH_L) begin
         phase_w = PH_CONV;
         if (b == CH_LO_L) begin
            size_w = ssp_pkg::SIZE_LL;
            done   = 1'b1;
         end else begin
            size_w = ssp_pkg::SIZE_L;
            ph     = PH_CONV;
         end
      end

      // conversion letter
      if (!done && ph == PH_CONV) begin
         cls  = classify(b);
         done = 1'b1;
         if (cls[3:0] == ssp_pkg::KIND_SET) begin
            phase_w      = PH_SET;
            first_done_w = 1'b0;
            pend_w       = PEND_NONE;
         end else begin
            emit       = 1'b1;
            emit_kind  = cls[3:0];
            emit_upper = cls[4];
         end
      end

      // byte after a caret: a closing bracket here is a member
      if (!done && ph == PH_CARET) begin
         phase_w = PH_SET;
         if (b == CH_RBRACK) begin
            mask[CH_RBRACK[CW-1:0]] = 1'b1;
            done = 1'b1;
         end else begin
            ph = PH_SET;
         end
      end

      // scanset body
      if (!done && ph == PH_SET) begin
         if (!first_done_ff) begin
            first_done_w = 1'b1;
            if (b == CH_RBRACK) begin
               mask[CH_RBRACK[CW-1:0]] = 1'b1;
               done = 1'b1;
            end else if (b == CH_CARET) begin
               negated_w = 1'b1;
               set_all   = 1'b1;
               phase_w   = PH_CARET;
               done      = 1'b1;
            end
         end
         if (!done) begin
            if (pend_ff == PEND_CHAR) begin
               if (b == CH_DASH) begin
                  pend_w = PEND_DASH;
                  done   = 1'b1;
               end else begin
                  mask[pend_char_ff] = 1'b1;
                  pend_w = PEND_NONE;
               end
            end else if (pend_ff == PEND_DASH) begin
               done = 1'b1;
               if (b == CH_RBRACK) begin
                  mask[pend_char_ff]    = 1'b1;
                  mask[CH_DASH[CW-1:0]] = 1'b1;
                  emit      = 1'b1;
                  emit_kind = ssp_pkg::KIND_SET;
               end else if (b == CH_NUL) begin
                  emit      = 1'b1;
                  emit_kind = ssp_pkg::KIND_UNKNOWN;
               end else begin
                  mask   = range_mask;
                  pend_w = PEND_NONE;
               end
            end
         end
         if (!done) begin
            done = 1'b1;
            if (b == CH_RBRACK) begin
               emit      = 1'b1;
               emit_kind = ssp_pkg::KIND_SET;
            end else if (b == CH_NUL) begin
               emit      = 1'b1;
               emit_kind = ssp_pkg::KIND_UNKNOWN;
            end else if (!b[7]) begin
               pend_char_w = b[CW-1:0];
               pend_w      = PEND_CHAR;
            end
         end
      end

      // apply member changes to the set
      if (set_all) begin
         set_work = '1;
      end else if (negated_ff) begin
         set_work = set_ff & ~mask;
      end else begin
         set_work = set_ff | mask;
      end

      // descriptor fields take the registered state and the updated set, then everything clears
      if (emit) begin
         phase_in      = PH_START;
         accum_in      = '0;
         arg_pos_in    = '0;
         suppress_in   = 1'b0;
         group_in      = 1'b0;
         alloc_in      = 1'b0;
         size_in       = ssp_pkg::SIZE_NONE;
         set_in        = '0;
         negated_in    = 1'b0;
         first_done_in = 1'b0;
         pend_char_in  = '0;
         pend_in       = PEND_NONE;
      end else begin
         phase_in      = phase_w;
         accum_in      = accum_w;
         arg_pos_in    = arg_pos_w;
         suppress_in   = suppress_w;
         group_in      = group_w;
         alloc_in      = alloc_w;
         size_in       = size_w;
         set_in        = set_work;
         negated_in    = negated_w;
         first_done_in = first_done_w;
         pend_char_in  = pend_char_w;
         pend_in       = pend_w;
      end
   end

   // input register, parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_START;
         accum_ff      <= '0;
         arg_pos_ff    <= '0;
         suppress_ff   <= 1'b0;
         group_ff      <= 1'b0;
         alloc_ff      <= 1'b0;
         size_ff       <= ssp_pkg::SIZE_NONE;
         set_ff        <= '0;
         negated_ff    <= 1'b0;
         first_done_ff <= 1'b0;
         pend_char_ff  <= '0;
         pend_ff       <= PEND_NONE;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (fire) begin
            phase_ff      <= phase_in;
            accum_ff      <= accum_in;
            arg_pos_ff    <= arg_pos_in;
            suppress_ff   <= suppress_in;
            group_ff      <= group_in;
            alloc_ff      <= alloc_in;
            size_ff       <= size_in;
            set_ff        <= set_in;
            negated_ff    <= negated_in;
            first_done_ff <= first_done_in;
            pend_char_ff  <= pend_char_in;
            pend_ff       <= pend_in;
         end
         if (fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // payload registers
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.fmt_byte;
      end
      if (fire && emit) begin
         rsp_arg_ff      <= 16'(arg_pos_ff);
         rsp_suppress_ff <= suppress_ff;
         rsp_group_ff    <= group_ff;
         rsp_alloc_ff    <= alloc_ff;
         rsp_upper_ff    <= emit_upper;
         rsp_width_ff    <= 16'(accum_ff);
         rsp_size_ff     <= (phase_ff == PH_H || phase_ff == PH_L) ?
                            ((phase_ff == PH_H) ? ssp_pkg::SIZE_H : ssp_pkg::SIZE_L) :
                            size_ff;
         rsp_kind_ff     <= emit_kind;
         rsp_set_ff      <= (emit_kind == ssp_pkg::KIND_SET) ? set_work : '0;
      end
   end

   // result channel
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.arg_position    = rsp_arg_ff;
   assign rsp_chan.suppress_assign = rsp_suppress_ff;
   assign rsp_chan.group_digits    = rsp_group_ff;
   assign rsp_chan.allocate_buffer = rsp_alloc_ff;
   assign rsp_chan.upper_case      = rsp_upper_ff;
   assign rsp_chan.field_width     = rsp_width_ff;
   assign rsp_chan.size_modifier   = rsp_size_ff;
   assign rsp_chan.conv_kind       = rsp_kind_ff;
   assign rsp_chan.set_low_bits    = rsp_set_ff[63:0];
   assign rsp_chan.set_high_bits   = rsp_set_ff[127:64];

endmodule

@@ tb/sv/tb_scanf_spec_parser.sv @@
// self-checking testbench for the scanf specification parser: directed bytes, then random specs
module tb_scanf_spec_parser;

   // one descriptor as it leaves the parser
   typedef struct packed {
      ssp_pkg::pos_type      arg_position;
      logic                  suppress_assign;
      logic                  group_digits;
      logic                  allocate_buffer;
      logic                  upper_case;
      ssp_pkg::pos_type      field_width;
      ssp_pkg::size_type     size_modifier;
      ssp_pkg::kind_type     conv_kind;
      ssp_pkg::half_set_type set_low_bits;
      ssp_pkg::half_set_type set_high_bits;
   } spec_desc_type;

   // one row of the directed table; the typed fields hold only where typed is set
   typedef struct packed {
      logic [7:0]        fmt;
      logic              typed;
      ssp_pkg::kind_type kind;
      ssp_pkg::pos_type  width;
      ssp_pkg::size_type size;
      logic [3:0]        flags;
   } probe_row_type;

   // parser phases and scanset range tracking
   typedef enum logic [3:0] {
      P_START, P_ARGNUM, P_FLAGS, P_WIDTH, P_LEN, P_H, P_L, P_CONV, P_SET, P_CARET
   } parse_phase_type;
   typedef enum logic [1:0] {PEND_NONE, PEND_CHAR, PEND_DASH} range_stage_type;

   localparam logic [3:0] FLG_SUPPRESS = 4'b0001;
   localparam logic [3:0] FLG_GROUP    = 4'b0010;
   localparam logic [3:0] FLG_ALLOC    = 4'b0100;
   localparam logic [3:0] FLG_UPPER    = 4'b1000;
   localparam logic [7:0] END_OF_FORMAT = 8'h00;
   localparam int unsigned NUM_MAX      = 65535;
   localparam int TOP_CHAR              = ssp_pkg::SET_CHARS - 1;
   localparam int WATCHDOG_LIMIT        = 2000;
   localparam int MAX_REPORTS           = 10;

   logic clock;
   logic reset;

   ssp_req_if req_chan ();
   ssp_rsp_if rsp_chan ();

   scanf_spec_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   parse_phase_type   parse_phase    = P_START;
   int unsigned       number_value   = 0;
   int unsigned       position_value = 0;
   logic              seen_suppress  = 1'b0;
   logic              seen_group     = 1'b0;
   logic              seen_alloc     = 1'b0;
   logic              seen_upper     = 1'b0;
   ssp_pkg::size_type size_value     = ssp_pkg::SIZE_NONE;
   ssp_pkg::set_type  scanset        = '0;
   logic              set_negated    = 1'b0;
   logic              set_started    = 1'b0;
   logic [7:0]        range_start    = 8'h00;
   range_stage_type   range_stage    = PEND_NONE;

   spec_desc_type expected_specs [$];
   logic [7:0] format_text [$];
   string      conv_letters = "diubBoOxXfFaAeEgGcs[pn";
   int         mismatches  = 0;
   int         spec_count  = 0;
   int         cycle_count = 0;

   // directed bytes: simple spec, end of format, top byte, saturation, zero position,
   // all flags, negated scanset with literal bracket and range, unclosed scanset
   probe_row_type probe_rows [0:24] = '{
      '{"d",   1'b1, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{8'h00, 1'b1, ssp_pkg::KIND_UNKNOWN, 16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{8'hFF, 1'b1, ssp_pkg::KIND_UNKNOWN, 16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"9",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"9",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"9",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"9",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"9",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"d",   1'b1, ssp_pkg::KIND_INT,     16'hFFFF, ssp_pkg::SIZE_NONE, 4'b0000},
      '{"0",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"$",   1'b1, ssp_pkg::KIND_UNKNOWN, 16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"*",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"'",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"m",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"L",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"X",   1'b1, ssp_pkg::KIND_HEX,     16'd0,    ssp_pkg::SIZE_BIG_L,
        FLG_SUPPRESS | FLG_GROUP | FLG_ALLOC | FLG_UPPER},
      '{"[",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"^",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"]",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"a",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"-",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"c",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"]",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{"[",   1'b0, ssp_pkg::KIND_INT,     16'd0,    ssp_pkg::SIZE_NONE, 4'b0000},
      '{8'h00, 1'b1, ssp_pkg::KIND_UNKNOWN, 16'd0,    ssp_pkg::SIZE_NONE, 4'b0000}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // saturating decimal accumulate
   function automatic int unsigned add_digit(input int unsigned acc, input logic [7:0] b);
      int unsigned sum;
      sum = acc * 10 + int'(b - "0");
      return (sum > NUM_MAX) ? NUM_MAX : sum;
   endfunction

   // add or remove one scanset member
   function automatic void mark_member(input logic [7:0] c);
      scanset[c[6:0]] = ~set_negated;
   endfunction

   // build the descriptor and return to the idle parse state
   function automatic spec_desc_type close_spec(input ssp_pkg::kind_type kind);
      spec_desc_type d;
      d.arg_position    = position_value[15:0];
      d.suppress_assign = seen_suppress;
      d.group_digits    = seen_group;
      d.allocate_buffer = seen_alloc;
      d.upper_case      = seen_upper;
      d.field_width     = number_value[15:0];
      d.size_modifier   = size_value;
      d.conv_kind       = kind;
      d.set_low_bits    = (kind == ssp_pkg::KIND_SET) ? scanset[63:0] : '0;
      d.set_high_bits   = (kind == ssp_pkg::KIND_SET) ? scanset[127:64] : '0;
      parse_phase    = P_START;
      number_value   = 0;
      position_value = 0;
      seen_suppress  = 1'b0;
      seen_group     = 1'b0;
      seen_alloc     = 1'b0;
      seen_upper     = 1'b0;
      size_value     = ssp_pkg::SIZE_NONE;
      scanset        = '0;
      set_negated    = 1'b0;
      set_started    = 1'b0;
      range_start    = 8'h00;
      range_stage    = PEND_NONE;
      return d;
   endfunction

   // conversion letter to kind, upper-case letters flag themselves
   function automatic ssp_pkg::kind_type letter_kind(input logic [7:0] b);
      case (b)
         "d", "i": return ssp_pkg::KIND_INT;
         "u":      return ssp_pkg::KIND_UNSIGN;
         "b":      return ssp_pkg::KIND_BIN;
         "o":      return ssp_pkg::KIND_OCT;
         "x":      return ssp_pkg::KIND_HEX;
         "f":      return ssp_pkg::KIND_FLT_F;
         "a":      return ssp_pkg::KIND_FLT_A;
         "e":      return ssp_pkg::KIND_FLT_E;
         "g":      return ssp_pkg::KIND_FLT_G;
         "B": begin seen_upper = 1'b1; return ssp_pkg::KIND_BIN; end
         "O": begin seen_upper = 1'b1; return ssp_pkg::KIND_OCT; end
         "X": begin seen_upper = 1'b1; return ssp_pkg::KIND_HEX; end
         "F": begin seen_upper = 1'b1; return ssp_pkg::KIND_FLT_F; end
         "A": begin seen_upper = 1'b1; return ssp_pkg::KIND_FLT_A; end
         "E": begin seen_upper = 1'b1; return ssp_pkg::KIND_FLT_E; end
         "G": begin seen_upper = 1'b1; return ssp_pkg::KIND_FLT_G; end
         "c":      return ssp_pkg::KIND_CHAR;
         "s":      return ssp_pkg::KIND_STRING;
         "[":      return ssp_pkg::KIND_SET;
         "p":      return ssp_pkg::KIND_POINTER;
         "n":      return ssp_pkg::KIND_COUNT;
         default:  return ssp_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   // advance the parse by one format byte, maybe finishing a descriptor
   task automatic parse_step(input logic [7:0] b, output bit done, output spec_desc_type d);
      bit                digit;
      bit                stop;
      bit                handled;
      ssp_pkg::kind_type kind;
      int                hi;
      digit = (b >= "0") && (b <= "9");
      done  = 1'b0;
      d     = '0;
      stop  = 1'b0;
      while (!stop) begin
         case (parse_phase)
            P_START: begin
               if (digit) begin
                  number_value = add_digit(number_value, b);
                  parse_phase = P_ARGNUM;
                  stop = 1'b1;
               end else begin
                  parse_phase = P_FLAGS;
               end
            end
            P_ARGNUM: begin
               if (digit) begin
                  number_value = add_digit(number_value, b);
                  stop = 1'b1;
               end else if (b == "$" && number_value != 0) begin
                  position_value = number_value;
                  number_value = 0;
                  parse_phase = P_FLAGS;
                  stop = 1'b1;
               end else begin
                  parse_phase = P_LEN;
               end
            end
            P_FLAGS: begin
               stop = 1'b1;
               if (b == "*") seen_suppress = 1'b1;
               else if (b == "'") seen_group = 1'b1;
               else if (b == "m") seen_alloc = 1'b1;
               else if (digit) begin
                  number_value = add_digit(number_value, b);
                  parse_phase = P_WIDTH;
               end else begin
                  parse_phase = P_LEN;
                  stop = 1'b0;
               end
            end
            P_WIDTH: begin
               if (digit) begin
                  number_value = add_digit(number_value, b);
                  stop = 1'b1;
               end else begin
                  parse_phase = P_LEN;
               end
            end
            P_LEN: begin
               stop = 1'b1;
               case (b)
                  "h": parse_phase = P_H;
                  "l": parse_phase = P_L;
                  "L": begin size_value = ssp_pkg::SIZE_BIG_L; parse_phase = P_CONV; end
                  "j": begin size_value = ssp_pkg::SIZE_J; parse_phase = P_CONV; end
                  "z": begin size_value = ssp_pkg::SIZE_Z; parse_phase = P_CONV; end
                  "t": begin size_value = ssp_pkg::SIZE_T; parse_phase = P_CONV; end
                  default: begin parse_phase = P_CONV; stop = 1'b0; end
               endcase
            end
            P_H: begin
               parse_phase = P_CONV;
               if (b == "h") begin
                  size_value = ssp_pkg::SIZE_HH;
                  stop = 1'b1;
               end else begin
                  size_value = ssp_pkg::SIZE_H;
               end
            end
            P_L: begin
               parse_phase = P_CONV;
               if (b == "l") begin
                  size_value = ssp_pkg::SIZE_LL;
                  stop = 1'b1;
               end else begin
                  size_value = ssp_pkg::SIZE_L;
               end
            end
            P_CONV: begin
               stop = 1'b1;
               kind = letter_kind(b);
               if (kind == ssp_pkg::KIND_SET) begin
                  parse_phase = P_SET;
                  set_started = 1'b0;
                  range_stage = PEND_NONE;
               end else begin
                  d = close_spec(kind);
                  done = 1'b1;
               end
            end
            P_CARET: begin
               parse_phase = P_SET;
               if (b == "]") begin
                  mark_member(b);
                  stop = 1'b1;
               end
            end
            default: begin
               // scanset body
               stop = 1'b1;
               if (!set_started && b == "]") begin
                  set_started = 1'b1;
                  mark_member(b);
               end else if (!set_started && b == "^") begin
                  set_started = 1'b1;
                  set_negated = 1'b1;
                  scanset = '1;
                  parse_phase = P_CARET;
               end else begin
                  set_started = 1'b1;
                  handled = 1'b0;
                  if (range_stage == PEND_CHAR) begin
                     if (b == "-") begin
                        range_stage = PEND_DASH;
                        handled = 1'b1;
                     end else begin
                        mark_member(range_start);
                        range_stage = PEND_NONE;
                     end
                  end else if (range_stage == PEND_DASH) begin
                     handled = 1'b1;
                     if (b == "]") begin
                        // trailing dash is a literal member
                        mark_member(range_start);
                        mark_member("-");
                        d = close_spec(ssp_pkg::KIND_SET);
                        done = 1'b1;
                     end else if (b == END_OF_FORMAT) begin
                        d = close_spec(ssp_pkg::KIND_UNKNOWN);
                        done = 1'b1;
                     end else begin
                        hi = (b > TOP_CHAR) ? TOP_CHAR : int'(b);
                        for (int c = int'(range_start); c <= hi; c++) mark_member(8'(c));
                        range_stage = PEND_NONE;
                     end
                  end
                  if (!handled) begin
                     if (b == "]") begin
                        d = close_spec(ssp_pkg::KIND_SET);
                        done = 1'b1;
                     end else if (b == END_OF_FORMAT) begin
                        d = close_spec(ssp_pkg::KIND_UNKNOWN);
                        done = 1'b1;
                     end else if (b <= TOP_CHAR) begin
                        range_start = b;
                        range_stage = PEND_CHAR;
                     end
                  end
               end
            end
         endcase
      end
   endtask

   // decimal digits for a position or a width; sometimes zeros, sometimes long runs
   task automatic push_digits();
      int unsigned count;
      bit zeros;
      count = ($urandom_range(5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      zeros = ($urandom_range(7) == 0);
      repeat (count) format_text.push_back(zeros ? "0" : 8'("0" + $urandom_range(9)));
   endtask

   // one random specification, mostly well formed
   task automatic gen_spec();
      logic [7:0] letter;
      logic [7:0] lo;
      logic [7:0] hi;
      if ($urandom_range(99) < 8) begin
         // noise bytes
         repeat ($urandom_range(1, 3)) format_text.push_back(8'($urandom_range(255)));
      end else begin
         // optional argument position, usually closed by a dollar
         if ($urandom_range(3) == 0) begin
            push_digits();
            if ($urandom_range(4) != 0) format_text.push_back("$");
         end
         // flags
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(2))
               0: format_text.push_back("*");
               1: format_text.push_back("'");
               default: format_text.push_back("m");
            endcase
         end
         if ($urandom_range(1) == 0) push_digits();
         // size modifier
         case ($urandom_range(8))
            1: begin format_text.push_back("h"); format_text.push_back("h"); end
            2: format_text.push_back("h");
            3: format_text.push_back("l");
            4: begin format_text.push_back("l"); format_text.push_back("l"); end
            5: format_text.push_back("L");
            6: format_text.push_back("j");
            7: format_text.push_back("z");
            8: format_text.push_back("t");
            default: ;
         endcase
         // conversion letter, scansets favored
         case ($urandom_range(19))
            0: letter = 8'($urandom_range(255));
            1: letter = END_OF_FORMAT;
            2, 3, 4, 5, 6: letter = "[";
            default: letter = conv_letters[$urandom_range(conv_letters.len() - 1)];
         endcase
         format_text.push_back(letter);
         if (letter == "[") begin
            if ($urandom_range(2) == 0) format_text.push_back("^");
            if ($urandom_range(3) == 0) format_text.push_back("]");
            repeat ($urandom_range(0, 6)) begin
               lo = 8'($urandom_range(1, TOP_CHAR));
               if (lo == "]") lo = "a";
               case ($urandom_range(5))
                  0: format_text.push_back(8'($urandom_range(128, 255)));
                  1, 2: begin
                     case ($urandom_range(3))
                        0: hi = 8'($urandom_range(128, 255));
                        1: hi = 8'($urandom_range(1, TOP_CHAR));
                        default: hi = 8'($urandom_range(lo, TOP_CHAR));
                     endcase
                     format_text.push_back(lo);
                     format_text.push_back("-");
                     format_text.push_back(hi);
                  end
                  default: format_text.push_back(lo);
               endcase
            end
            case ($urandom_range(9))
               0: format_text.push_back(END_OF_FORMAT);
               1: begin format_text.push_back("-"); format_text.push_back("]"); end
               default: format_text.push_back("]");
            endcase
         end
      end
   endtask

   // offer one byte, wait for acceptance, queue what it should produce
   task automatic send_byte(input logic [7:0] b, input bit typed, input spec_desc_type fixed,
                            input bit calm);
      bit            done;
      spec_desc_type d;
      while (!calm && $urandom_range(99) < 15) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.fmt_byte <= b;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      parse_step(b, done, d);
      if (typed) begin
         d = fixed;
         done = 1'b1;
      end
      if (done) expected_specs.push_back(d);
   endtask

   // one field against its expectation
   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("descriptor %0d: %s expected %h got %h", spec_count, name, want, got);
      end
   endtask

   // result side: random back-pressure with a quiet window
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_chan.ready <= (cycle_count >= 600 && cycle_count < 1000) ||
                        ($urandom_range(99) >= 15);
   end

   // descriptor check
   always @(posedge clock) begin
      spec_desc_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_specs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("descriptor %0d: none expected, kind %0d arrived",
                        spec_count, rsp_chan.conv_kind);
         end else begin
            want = expected_specs.pop_front();
            compare_field("arg_position", want.arg_position, rsp_chan.arg_position);
            compare_field("suppress_assign", want.suppress_assign, rsp_chan.suppress_assign);
            compare_field("group_digits", want.group_digits, rsp_chan.group_digits);
            compare_field("allocate_buffer", want.allocate_buffer, rsp_chan.allocate_buffer);
            compare_field("upper_case", want.upper_case, rsp_chan.upper_case);
            compare_field("field_width", want.field_width, rsp_chan.field_width);
            compare_field("size_modifier", want.size_modifier, rsp_chan.size_modifier);
            compare_field("conv_kind", want.conv_kind, rsp_chan.conv_kind);
            compare_field("set_low_bits", want.set_low_bits, rsp_chan.set_low_bits);
            compare_field("set_high_bits", want.set_high_bits, rsp_chan.set_high_bits);
         end
         spec_count++;
      end
   end

   // watchdog on cycles with no item moving
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      spec_desc_type fixed;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.fmt_byte = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (probe_rows[i]) begin
         fixed = '0;
         fixed.conv_kind       = probe_rows[i].kind;
         fixed.field_width     = probe_rows[i].width;
         fixed.size_modifier   = probe_rows[i].size;
         fixed.suppress_assign = |(probe_rows[i].flags & FLG_SUPPRESS);
         fixed.group_digits    = |(probe_rows[i].flags & FLG_GROUP);
         fixed.allocate_buffer = |(probe_rows[i].flags & FLG_ALLOC);
         fixed.upper_case      = |(probe_rows[i].flags & FLG_UPPER);
         send_byte(probe_rows[i].fmt, probe_rows[i].typed, fixed, 1'b0);
      end

      // random specifications
      while (format_text.size() < 1300) gen_spec();
      foreach (format_text[i]) begin
         if (i == 700) begin
            // hold off until every descriptor is out
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (expected_specs.size() != 0);
         end
         send_byte(format_text[i], 1'b0, '0, (i >= 400 && i < 700));
      end

      // drain
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_specs.size() != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
src/ssp_pkg.sv
src/ssp_if.sv
src/ssp_digit_acc.sv
src/scanf_spec_parser.sv
tb/sv/tb_scanf_spec_parser.sv
